### rtl/core/assert_macros.svh
// Assertion macros shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TKL_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tracker assertion failed");
`define TKL_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tracker implication failed");
`else
`define TKL_ASSERT(label, prop)
`define TKL_ASSERT_IMPL(label, ante, cons)
`endif
`endif

### rtl/core/tkl_pkg.sv
// Constants shared by the top-K tracker files.
package tkl_pkg;
	localparam int FIELD_BITS = 48;
	localparam int RANK_BITS  = 4;
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;
endpackage

### rtl/core/tkl_cell.sv
// One slot of the sorted list: holds a size and address pair.
`include "assert_macros.svh"
module tkl_cell #(
	parameter int W = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         insert_en,
	input  logic [W-1:0] new_size,
	input  logic [W-1:0] new_addr,
	input  logic         prev_less,
	input  logic [W-1:0] prev_size,
	input  logic [W-1:0] prev_addr,
	output logic         less,
	output logic [W-1:0] size,
	output logic [W-1:0] addr
);
	import tkl_pkg::*;

	logic [W-1:0] size_q;
	logic [W-1:0] addr_q;

	assign less = new_size > size_q;
	assign size = size_q;
	assign addr = addr_q;

	// the new pair lands in the first smaller slot; slots after it take their neighbour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			addr_q <= '0;
		end else if (insert_en && less) begin
			if (prev_less) begin
				size_q <= prev_size;
				addr_q <= prev_addr;
			end else begin
				size_q <= new_size;
				addr_q <= new_addr;
			end
		end
	end

	`TKL_ASSERT(a_sorted, prev_size >= size_q)
	`TKL_ASSERT_IMPL(a_less_chain, prev_less, less)
	`TKL_ASSERT_IMPL(a_hold_idle, !insert_en, ##1 $stable(size_q))
endmodule

### rtl/core/top_k_largest_tracker.sv
// Top level of the top-K largest tracker: cell chain and result register.
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per operation:
//   op selects insert (block_size, block_address) or read (rank).
//   Output channel (out_valid / out_stall) returns exactly one beat per
//   input beat: accepted and placed_rank for inserts, entry_size and
//   entry_address for reads; the unused fields read as zero.
//   The result is registered and shows in the cycle after its beat is taken.
//   Throughput is one beat per cycle while the receiver does not stall,
//   set by the single compare and shift step all cells make in parallel.
//   The list is kept sorted by descending size; an insert enters only if
//   it is strictly larger than the last slot, goes after equal sizes and
//   pushes the last slot out. A read at a rank beyond the list gives zero.
//   Reset clears every slot to size 0, address 0 (empty) and drops any
//   pending result; no clearing pass is needed.
//   While the receiver stalls a held result, in_stall is raised and the
//   list does not change; the result stays on the output unchanged.
`include "assert_macros.svh"
module top_k_largest_tracker #(
	parameter int LIST_DEPTH = 16,
	parameter int VALUE_BITS = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [tkl_pkg::FIELD_BITS-1:0] block_size,
	input  logic [tkl_pkg::FIELD_BITS-1:0] block_address,
	input  logic [tkl_pkg::RANK_BITS-1:0]  rank,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           accepted,
	output logic [tkl_pkg::RANK_BITS-1:0]  placed_rank,
	output logic [tkl_pkg::FIELD_BITS-1:0] entry_size,
	output logic [tkl_pkg::FIELD_BITS-1:0] entry_address
);
	import tkl_pkg::*;

	localparam int IDX_BITS = $clog2(LIST_DEPTH);

	logic                  take;
	logic                  insert_en;
	logic [VALUE_BITS-1:0] new_size;
	logic [VALUE_BITS-1:0] new_addr;
	logic [LIST_DEPTH-1:0] less_w;
	logic [VALUE_BITS-1:0] size_w [LIST_DEPTH];
	logic [VALUE_BITS-1:0] addr_w [LIST_DEPTH];
	logic [IDX_BITS-1:0]   pos;
	logic [IDX_BITS-1:0]   sel;
	logic                  in_range;

	logic                  out_valid_q;
	logic                  accepted_q;
	logic [RANK_BITS-1:0]  placed_rank_q;
	logic [FIELD_BITS-1:0] entry_size_q;
	logic [FIELD_BITS-1:0] entry_address_q;

	assign in_stall  = out_valid_q && out_stall;
	assign take      = in_valid && !in_stall;
	assign insert_en = take && (op == OP_INSERT);
	assign new_size  = VALUE_BITS'(block_size);
	assign new_addr  = VALUE_BITS'(block_address);

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			tkl_cell #(.W(VALUE_BITS)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.insert_en (insert_en),
				.new_size  (new_size),
				.new_addr  (new_addr),
				.prev_less (1'b0),
				.prev_size ({VALUE_BITS{1'b1}}),
				.prev_addr ('0),
				.less      (less_w[i]),
				.size      (size_w[i]),
				.addr      (addr_w[i])
			);
		end else begin : g_body
			tkl_cell #(.W(VALUE_BITS)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.insert_en (insert_en),
				.new_size  (new_size),
				.new_addr  (new_addr),
				.prev_less (less_w[i-1]),
				.prev_size (size_w[i-1]),
				.prev_addr (addr_w[i-1]),
				.less      (less_w[i]),
				.size      (size_w[i]),
				.addr      (addr_w[i])
			);
		end
	end

	// first slot that the new size beats
	always_comb begin
		pos = '0;
		for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
			if (less_w[i]) pos = IDX_BITS'(i);
		end
	end

	assign in_range = 32'(rank) < LIST_DEPTH;
	assign sel      = IDX_BITS'(rank);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			accepted_q      <= 1'b0;
			placed_rank_q   <= '0;
			entry_size_q    <= '0;
			entry_address_q <= '0;
			if (op == OP_INSERT) begin
				if (less_w[LIST_DEPTH-1]) begin
					accepted_q    <= 1'b1;
					placed_rank_q <= RANK_BITS'(pos);
				end
			end else if (in_range) begin
				entry_size_q    <= FIELD_BITS'(size_w[sel]);
				entry_address_q <= FIELD_BITS'(addr_w[sel]);
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign placed_rank   = placed_rank_q;
	assign entry_size    = entry_size_q;
	assign entry_address = entry_address_q;

	`TKL_ASSERT_IMPL(a_stall_needs_result, in_stall, out_valid_q)
	`TKL_ASSERT_IMPL(a_take_gives_result, take, ##1 out_valid_q)
	`TKL_ASSERT_IMPL(a_insert_no_entry, out_valid_q && accepted_q,
		entry_size_q == '0 && entry_address_q == '0)
endmodule

### bench/tb_top.sv
// Self-checking bench for the top-K largest tracker: random beats, own model of the kept list.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tkl_pkg::*;

	localparam int KEPT_DEPTH     = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 60;
	localparam int PHASE_ITEMS    = 160;

	typedef struct packed {
		logic                  op;
		logic [FIELD_BITS-1:0] block_size;
		logic [FIELD_BITS-1:0] block_address;
		logic [RANK_BITS-1:0]  rank;
	} tracker_op_t;

	typedef struct packed {
		logic                  accepted;
		logic [RANK_BITS-1:0]  placed_rank;
		logic [FIELD_BITS-1:0] entry_size;
		logic [FIELD_BITS-1:0] entry_address;
	} tracker_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  op = OP_INSERT;
	logic [FIELD_BITS-1:0] block_size = '0;
	logic [FIELD_BITS-1:0] block_address = '0;
	logic [RANK_BITS-1:0]  rank = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  accepted;
	logic [RANK_BITS-1:0]  placed_rank;
	logic [FIELD_BITS-1:0] entry_size;
	logic [FIELD_BITS-1:0] entry_address;

	tracker_op_t           pending_ops[$];
	tracker_result_t       expected_results[$];
	logic [FIELD_BITS-1:0] offered_sizes[$];
	logic [FIELD_BITS-1:0] kept_size[KEPT_DEPTH];
	logic [FIELD_BITS-1:0] kept_address[KEPT_DEPTH];

	int unsigned sender_idle_pct = 36;
	int unsigned receiver_idle_pct = 80;
	int          fail_count = 0;
	int          quiet_cycles = 0;
	int          hold_left = 0;
	logic        hold_wanted = 1'b0;
	logic        hold_done = 1'b0;
	logic        in_taken = 1'b0;

	top_k_largest_tracker uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.block_size   (block_size),
		.block_address(block_address),
		.rank         (rank),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.accepted     (accepted),
		.placed_rank  (placed_rank),
		.entry_size   (entry_size),
		.entry_address(entry_address)
	);

	always #5 clk = ~clk;

	// Update the kept list for one beat and return the result it must produce.
	function automatic tracker_result_t apply_to_kept_list(tracker_op_t beat);
		tracker_result_t res;
		int              slot;
		int              i;
		res = '0;
		if (beat.op == OP_INSERT) begin
			if (beat.block_size > kept_size[KEPT_DEPTH-1]) begin
				slot = 0;
				while (kept_size[slot] >= beat.block_size)
					slot++;
				for (i = KEPT_DEPTH - 1; i > slot; i--) begin
					kept_size[i]    = kept_size[i-1];
					kept_address[i] = kept_address[i-1];
				end
				kept_size[slot]    = beat.block_size;
				kept_address[slot] = beat.block_address;
				res.accepted       = 1'b1;
				res.placed_rank    = RANK_BITS'(slot);
			end
		end else if (int'(beat.rank) < KEPT_DEPTH) begin
			res.entry_size    = kept_size[beat.rank];
			res.entry_address = kept_address[beat.rank];
		end
		return res;
	endfunction

	function automatic tracker_op_t make_op(logic kind, logic [FIELD_BITS-1:0] size,
			logic [RANK_BITS-1:0] at);
		tracker_op_t beat;
		logic [63:0] raw;
		raw                 = {$urandom, $urandom};
		beat.op             = kind;
		beat.block_size     = size;
		beat.block_address  = raw[FIELD_BITS-1:0];
		beat.rank           = at;
		return beat;
	endfunction

	// Sender: hold the payload until taken, then advance or idle.
	always @(negedge clk) begin : sender
		tracker_op_t next_beat;
		if (!in_valid || in_taken) begin
			if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				next_beat     = pending_ops.pop_front();
				in_valid      <= 1'b1;
				op            <= next_beat.op;
				block_size    <= next_beat.block_size;
				block_address <= next_beat.block_address;
				rank          <= next_beat.rank;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: one long hold-off once asked, random stalls otherwise.
	always @(negedge clk) begin : receiver
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_wanted && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	always @(posedge clk) begin : monitor
		tracker_op_t     in_beat;
		tracker_result_t got;
		tracker_result_t want;
		in_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				in_beat = '{op: op, block_size: block_size, block_address: block_address,
					rank: rank};
				expected_results.push_back(apply_to_kept_list(in_beat));
			end
			if (out_valid && !out_stall) begin
				got = '{accepted: accepted, placed_rank: placed_rank,
					entry_size: entry_size, entry_address: entry_address};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat: acc=%0b rank=%0d size=%h addr=%h",
							got.accepted, got.placed_rank, got.entry_size, got.entry_address);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected acc=%0b rank=%0d size=%h addr=%h, ",
								want.accepted, want.placed_rank, want.entry_size,
								want.entry_address,
								"got acc=%0b rank=%0d size=%h addr=%h",
								got.accepted, got.placed_rank,
								got.entry_size, got.entry_address);
					end
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", quiet_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		logic [FIELD_BITS-1:0] all_ones;
		logic [FIELD_BITS-1:0] size;
		logic [63:0]           raw;
		int                    phase;
		int                    n;
		int unsigned           pick;
		all_ones = '1;
		for (n = 0; n < KEPT_DEPTH; n++) begin
			kept_size[n]    = '0;
			kept_address[n] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// Directed: empty reads, zero size, largest size, ties, a full list, rejects.
		pending_ops.push_back(make_op(OP_READ, all_ones, 4'd0));
		pending_ops.push_back(make_op(OP_READ, '0, 4'd15));
		pending_ops.push_back(make_op(OP_INSERT, '0, 4'd15));
		pending_ops.push_back(make_op(OP_INSERT, all_ones, 4'd0));
		pending_ops.push_back(make_op(OP_INSERT, 48'd1, 4'd0));
		pending_ops.push_back(make_op(OP_INSERT, all_ones, all_ones[3:0]));
		pending_ops.push_back(make_op(OP_INSERT, 48'd1, 4'd0));
		for (n = 0; n < 12; n++)
			pending_ops.push_back(make_op(OP_INSERT, 48'd2, RANK_BITS'(n)));
		pending_ops.push_back(make_op(OP_INSERT, 48'd1, 4'd0));
		pending_ops.push_back(make_op(OP_INSERT, '0, 4'd0));
		pending_ops.push_back(make_op(OP_READ, 48'd5, 4'd15));
		pending_ops.push_back(make_op(OP_READ, 48'd5, 4'd0));
		pending_ops.push_back(make_op(OP_READ, all_ones, 4'd7));
		while (pending_ops.size() != 0)
			@(posedge clk);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct   = 36;
					receiver_idle_pct = 80;
				end
				1: begin
					sender_idle_pct   = 80;
					receiver_idle_pct = 36;
				end
				default: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
					hold_wanted       = 1'b1;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				raw  = {$urandom, $urandom};
				pick = $urandom_range(99);
				// Mix wide sizes, near-repeats of earlier ones, small sizes and all ones to hit ties and the boundary.
				if (pick < 50 || offered_sizes.size() == 0) begin
					size = raw[FIELD_BITS-1:0];
					offered_sizes.push_back(size);
				end else if (pick < 80) begin
					size = offered_sizes[$urandom_range(offered_sizes.size() - 1)]
						+ FIELD_BITS'($urandom_range(2)) - 1'b1;
				end else if (pick < 98) begin
					size = FIELD_BITS'($urandom_range(40));
				end else begin
					size = all_ones;
				end
				pending_ops.push_back(make_op(($urandom_range(99) < 40) ? OP_READ : OP_INSERT,
					size, RANK_BITS'($urandom_range(15))));
			end
			while (pending_ops.size() != 0)
				@(posedge clk);
		end

		while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
